### hdl/bmhq_pkg.sv
// Shared types, widths and codes for the binary max-heap queue.
package bmhq_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 8;
   localparam int TAG_W    = 14;
   localparam int OCC_W    = 6;
   localparam int REQ_W    = 2;
   localparam int STAT_W   = 2;

   // depth of the command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // classified command handed from front to back
   typedef struct packed {
      op_type            op;
      logic [STAT_W-1:0] status;
      entry_type         entry;
      logic [CNT_W-1:0]  occ;     // entry count after this word
   } cmd_type;

endpackage

### hdl/bmhq_ram.sv
// Generic RAM: one write port, two registered read ports.
module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### hdl/bmhq_front.sv
// Front end: tracks entry count, classifies requests, queues commands.
module bmhq_front import bmhq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [REQ_W-1:0] req_type,
   input  logic [KEY_W-1:0] req_in_priority,
   input  logic [TAG_W-1:0] req_in_tag,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  logic             cmd_pop
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [QCNT_W-1:0] level_ff, level_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   cmd_type           q_ff [QDEPTH];
   cmd_type           new_cmd;
   logic              accept;

   assign full      = (level_ff == QCNT_W'(QDEPTH));
   assign cmd_valid = (level_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;

   // classify against the count that holds once earlier words retire
   always_comb begin
      new_cmd.entry.key = req_in_priority;
      new_cmd.entry.tag = req_in_tag;
      new_cmd.status    = STATUS_OK;
      new_cmd.op        = OP_REPORT;
      new_cmd.occ       = count_ff;
      case (req_type)
         REQ_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               new_cmd.status = STATUS_FULL;
            end else begin
               new_cmd.op  = OP_INSERT;
               new_cmd.occ = count_ff + 1'b1;
            end
         end
         REQ_POP: begin
            if (count_ff == '0) begin
               new_cmd.status = STATUS_EMPTY;
            end else begin
               new_cmd.op  = OP_POP;
               new_cmd.occ = count_ff - 1'b1;
            end
         end
         REQ_PEEK: begin
            if (count_ff == '0) begin
               new_cmd.status = STATUS_EMPTY;
            end else begin
               new_cmd.op = OP_PEEK;
            end
         end
         default: ;  // unused code: ok, no change
      endcase
   end

   always_comb begin
      count_in  = accept ? new_cmd.occ : count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({accept, cmd_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         level_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         level_ff  <= level_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### hdl/bmhq_back.sv
// Back end: sift-up / sift-down sequencer over the heap RAM, result register.
module bmhq_back import bmhq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output logic [STAT_W-1:0] rsp_status,
   output logic [KEY_W-1:0]  rsp_out_priority,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP      = 7'b0000010,
      S_UP_CMP  = 7'b0000100,
      S_DN_LAST = 7'b0001000,
      S_DN      = 7'b0010000,
      S_DN_CMP  = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   entry_type         e_ff, e_in;          // entry being sifted
   entry_type         root_ff, root_in;    // mirror of heap slot 0
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   entry_type         res_entry_ff, res_entry_in;
   logic [CNT_W-1:0]  res_occ_ff, res_occ_in;
   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] o_status_ff, o_status_in;
   entry_type         o_entry_ff, o_entry_in;
   logic [CNT_W-1:0]  o_occ_ff, o_occ_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   entry_type         rd_data_a, rd_data_b;

   logic [CNT_W:0]    left_w, right_w;
   logic              right_ok;
   entry_type         big;
   logic [ADDR_W-1:0] big_pos;
   logic [ADDR_W-1:0] parent;

   bmhq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign left_w   = {{(CNT_W - ADDR_W){1'b0}}, pos_ff, 1'b1};
   assign right_w  = left_w + 1'b1;
   assign right_ok = (right_w < {1'b0, n_ff});
   assign parent   = ADDR_W'((pos_ff - 1'b1) >> 1);

   // larger child, left on a tie
   always_comb begin
      if (right_ok && (rd_data_b.key > rd_data_a.key)) begin
         big     = rd_data_b;
         big_pos = right_w[ADDR_W-1:0];
      end else begin
         big     = rd_data_a;
         big_pos = left_w[ADDR_W-1:0];
      end
   end

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      state_in      = state_ff;
      e_in          = e_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_occ_in    = res_occ_ff;
      out_valid_in  = out_valid_ff && !pop;
      o_status_in   = o_status_ff;
      o_entry_in    = o_entry_ff;
      o_occ_in      = o_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = e_ff;
      rd_addr_a     = left_w[ADDR_W-1:0];
      rd_addr_b     = right_w[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               res_status_in = cmd.status;
               res_occ_in    = cmd.occ;
               res_entry_in  = '0;
               e_in          = cmd.entry;
               n_in          = cmd.occ;
               unique case (cmd.op)
                  OP_INSERT: begin
                     pos_in   = ADDR_W'(cmd.occ - 1'b1);
                     state_in = S_UP;
                  end
                  OP_POP: begin
                     res_entry_in = root_ff;
                     pos_in       = '0;
                     rd_addr_a    = ADDR_W'(cmd.occ);   // old last slot
                     state_in     = (cmd.occ == '0) ? S_DONE : S_DN_LAST;
                  end
                  OP_PEEK: begin
                     res_entry_in = root_ff;
                     state_in     = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_UP: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a.key < e_ff.key) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_LAST: begin
            e_in     = rd_data_a;
            state_in = S_DN;
         end
         S_DN: begin
            if (left_w >= {1'b0, n_ff}) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (big.key > e_ff.key) begin
               wr_data  = big;
               pos_in   = big_pos;
               state_in = S_DN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               o_status_in  = res_status_ff;
               o_entry_in   = res_entry_ff;
               o_occ_in     = res_occ_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      root_in = (wr_en && (wr_addr == '0)) ? wr_data : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff          <= e_in;
      root_ff       <= root_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_occ_ff    <= res_occ_in;
      o_status_ff   <= o_status_in;
      o_entry_ff    <= o_entry_in;
      o_occ_ff      <= o_occ_in;
   end

   assign empty            = !out_valid_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_out_priority = o_entry_ff.key;
   assign rsp_out_tag      = o_entry_ff.tag;
   assign rsp_occupancy    = OCC_W'(o_occ_ff);

endmodule

### hdl/binary_max_heap_queue_core.sv
// Binary max-heap priority queue: top level.
// Use:
//   Request side is a queue write port: drive req_type, req_in_priority and
//   req_in_tag with push; a word is taken on a clock edge with push high and
//   full low. req_type: insert, pop highest, peek highest.
//   Response side is a queue read port: while empty is low the oldest result
//   word sits on rsp_status, rsp_out_priority, rsp_out_tag, rsp_occupancy;
//   pop high with empty low takes it. One response word per request word,
//   in request order.
// Flow:
//   Front end classifies a word the cycle it is taken (full / empty checks
//   against its own entry count) and queues it, two words deep.
//   Back end walks the heap RAM one level at a time (read, then compare and
//   write): insert climbs from the new last slot toward the root, pop takes
//   the old last entry and sifts it down from the root; peek and rejected
//   words only pass their result on.
// Reset: synchronous, clears counts, queue and state; heap RAM is not
//   cleared and needs no clearing pass (only filled slots are ever read).
// Stall: a result waiting in the output register holds the back end; the
//   front keeps taking words until its queue fills, then raises full.
module binary_max_heap_queue_core import bmhq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request queue port
   input  logic              push,
   output logic              full,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [KEY_W-1:0]  req_in_priority,
   input  logic [TAG_W-1:0]  req_in_tag,
   // response queue port
   output logic              empty,
   input  logic              pop,
   output logic [STAT_W-1:0] rsp_status,
   output logic [KEY_W-1:0]  rsp_out_priority,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // classify and buffer
   bmhq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_in_priority (req_in_priority),
      .req_in_tag      (req_in_tag),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // sift engine and result register
   bmhq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
